// ----- rtl/core/sqa_pkg.sv -----
// sqa_pkg: shared constants, codes and control types of the sensor quorum averager
// used by sqa_ctrl, sqa_datapath and sensor_quorum_averager_top
package sqa_pkg;

  localparam int NODE_COUNT = 8;
  localparam int SLOT_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int SUM_W      = 32 + SLOT_W;
  localparam int DIV_W      = SUM_W + (SUM_W % 2);
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] CMD_READING = 2'd0;
  localparam logic [1:0] CMD_ROUND   = 2'd1;
  localparam logic [1:0] CMD_LEADER  = 2'd2;

  localparam logic [1:0] REG_OWN_ID  = 2'd0;
  localparam logic [1:0] REG_WINDOW  = 2'd1;
  localparam logic [1:0] REG_QUORUM  = 2'd2;

  localparam logic [3:0] OWN_ID_RESET = 4'd1;
  localparam logic [7:0] WINDOW_RESET = 8'd15;
  localparam logic [3:0] QUORUM_RESET = 4'd3;

  typedef struct packed {
    logic              accept;
    logic              round;
    logic              scan;
    logic [SLOT_W-1:0] idx;
    logic              div_init;
    logic              div_step;
    logic              finish;
  } sqa_cmd_t;

  typedef struct packed {
    logic is_leader;
  } sqa_stat_t;

endpackage

// ----- rtl/core/sensor_quorum_averager_top.sv -----
// sensor_quorum_averager_top: top level joining sqa_ctrl and sqa_datapath
// depends on sqa_pkg, sqa_ctrl, sqa_datapath
//
// A reading or a leader select is taken and busy stays low, so such items
// may follow each other every cycle. A round while leader raises busy through
// the slot scan (ST_SCAN), one slot a cycle, the division (ST_DIV) and the
// result state (ST_EMIT); done is high in ST_EMIT with the result on the
// ports. done is high for that single cycle only and the receiver cannot
// stall it. A round while not leader produces no result and leaves busy low.
module sensor_quorum_averager_top
  import sqa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [7:0]  node_id,
  input  logic [31:0] reading_mc,
  input  logic        auth_ok,
  input  logic [31:0] now_seconds,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [31:0] round_number,
  output logic [31:0] round_time,
  output logic [31:0] mean_milli_c,
  output logic [7:0]  fresh_mask,
  output logic [3:0]  fresh_count,
  output logic        quorum_met
);

  sqa_cmd_t  cmd;
  sqa_stat_t stat;

  sqa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  sqa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .command      (command),
    .node_id      (node_id),
    .reading_mc   (reading_mc),
    .auth_ok      (auth_ok),
    .now_seconds  (now_seconds),
    .round_number (round_number),
    .round_time   (round_time),
    .mean_milli_c (mean_milli_c),
    .fresh_mask   (fresh_mask),
    .fresh_count  (fresh_count),
    .quorum_met   (quorum_met)
  );

endmodule

// ----- rtl/core/sqa_ctrl.sv -----
// sqa_ctrl: sequencer for accept, slot scan, mean division and result strobe
// depends on sqa_pkg
module sqa_ctrl
  import sqa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] command,
  input  sqa_stat_t  stat,
  output sqa_cmd_t   cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(NODE_COUNT - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             accept;
  logic             round_go;

  assign busy     = (state != ST_IDLE);
  assign done     = (state == ST_EMIT);
  assign accept   = start && !busy;
  assign round_go = accept && (command == CMD_ROUND) && stat.is_leader;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.accept = accept;
    cmd.round  = round_go;
    cmd.idx    = cnt[SLOT_W-1:0];
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (round_go) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (cnt == SCAN_LAST) begin
          cnt_next   = '0;
          state_next = ST_DIV;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DIV: begin
        if (cnt == '0) begin
          cmd.div_init = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
        if (cnt == DIV_LAST) begin
          cmd.finish = 1'b1;
          cnt_next   = '0;
          state_next = ST_EMIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_EMIT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  a_round_starts: assert property (@(posedge clk) disable iff (rst)
    round_go |=> (state == ST_SCAN) && (cnt == '0))
    else $error("accepted round did not start the scan");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe longer than one cycle");

  a_scan_to_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && (cnt == SCAN_LAST) |=> (state == ST_DIV) && cmd.div_init)
    else $error("scan did not hand over to division");

endmodule

// ----- rtl/core/sqa_datapath.sv -----
// sqa_datapath: config registers, node slot table, fresh-slot accumulator and
// two-bit-per-cycle divider for the mean; depends on sqa_pkg
module sqa_datapath
  import sqa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sqa_cmd_t    cmd,
  output sqa_stat_t   stat,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic [1:0]  command,
  input  logic [7:0]  node_id,
  input  logic [31:0] reading_mc,
  input  logic        auth_ok,
  input  logic [31:0] now_seconds,
  output logic [31:0] round_number,
  output logic [31:0] round_time,
  output logic [31:0] mean_milli_c,
  output logic [7:0]  fresh_mask,
  output logic [3:0]  fresh_count,
  output logic        quorum_met
);

  logic [3:0]  own_id;
  logic [7:0]  window;
  logic [3:0]  quorum;
  logic        is_leader;
  logic [31:0] round_counter;

  logic [NODE_COUNT-1:0] slot_valid;
  logic [31:0]           slot_reading [NODE_COUNT];
  logic [31:0]           slot_seen    [NODE_COUNT];

  logic [31:0]      now_q;
  logic [SUM_W-1:0] sum;
  logic [3:0]       count;
  logic [7:0]       mask;

  logic [DIV_W-1:0] quo, quo_next;
  logic [3:0]       rem, rem_next;
  logic             neg;

  logic              rd_write, own_write;
  logic [SLOT_W-1:0] rd_idx, own_idx;
  logic [31:0]       age;
  logic              fresh;
  logic [SUM_W-1:0]  mag;
  logic [DIV_W-1:0]  signed_q;
  logic [4:0]        sh;

  assign stat.is_leader = is_leader;

  assign rd_write  = cmd.accept && (command == CMD_READING) && auth_ok && (node_id != 8'd0)
                     && ({24'd0, node_id} <= 32'(NODE_COUNT));
  assign rd_idx    = SLOT_W'(node_id - 8'd1);
  assign own_write = cmd.round && (own_id != 4'd0) && ({28'd0, own_id} <= 32'(NODE_COUNT));
  assign own_idx   = SLOT_W'(own_id - 4'd1);

  assign age   = now_q - slot_seen[cmd.idx];
  assign fresh = slot_valid[cmd.idx] && (age < {24'd0, window});
  assign mag   = sum[SUM_W-1] ? (~sum + 1'b1) : sum;

  // restoring division, two quotient bits per cycle
  always_comb begin
    quo_next = quo;
    rem_next = rem;
    sh       = '0;
    for (int k = 0; k < 2; k++) begin
      sh       = {rem_next, quo_next[DIV_W-1]};
      quo_next = {quo_next[DIV_W-2:0], 1'b0};
      if (sh >= {1'b0, count}) begin
        rem_next    = 4'(sh - {1'b0, count});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = sh[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id        <= OWN_ID_RESET;
      window        <= WINDOW_RESET;
      quorum        <= QUORUM_RESET;
      is_leader     <= 1'b0;
      round_counter <= '0;
      slot_valid    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_OWN_ID: own_id <= cfg_data[3:0];
          REG_WINDOW: window <= cfg_data;
          REG_QUORUM: quorum <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.accept && (command == CMD_LEADER)) begin
        is_leader <= (node_id == {4'd0, own_id});
      end
      if (rd_write) begin
        slot_valid[rd_idx] <= 1'b1;
      end
      if (own_write) begin
        slot_valid[own_idx] <= 1'b1;
      end
      if (cmd.finish) begin
        round_counter <= round_counter + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_write) begin
      slot_reading[rd_idx] <= reading_mc;
      slot_seen[rd_idx]    <= now_seconds;
    end
    if (own_write) begin
      slot_reading[own_idx] <= reading_mc;
      slot_seen[own_idx]    <= now_seconds;
    end
    if (cmd.round) begin
      now_q <= now_seconds;
      sum   <= '0;
      count <= '0;
      mask  <= '0;
    end
    if (cmd.scan && fresh) begin
      sum           <= sum + SUM_W'(signed'(slot_reading[cmd.idx]));
      count         <= count + 4'd1;
      mask[cmd.idx] <= 1'b1;
    end
    if (cmd.div_init) begin
      quo <= DIV_W'(mag);
      rem <= '0;
      neg <= sum[SUM_W-1];
    end
    if (cmd.div_step) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign signed_q     = neg ? (~quo + 1'b1) : quo;
  assign mean_milli_c = (count == 4'd0) ? 32'd0 : signed_q[31:0];
  assign round_number = round_counter;
  assign round_time   = now_q;
  assign fresh_mask   = mask;
  assign fresh_count  = count;
  assign quorum_met   = (count >= quorum);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> ({28'd0, count} <= 32'(NODE_COUNT)) && ($countones(mask) == count))
    else $error("fresh count and mask disagree");

  a_round_step: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> round_counter == $past(round_counter) + 32'd1)
    else $error("round counter not advanced");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step && (count != 4'd0) |=> rem < count)
    else $error("divider remainder out of range");

endmodule
